// File: design/frm_pkg.sv
// Shared types, widths and tables for the fisheye rectification map.
// Used by the cell modules and the top level; depends on nothing.
`default_nettype none

package frm_pkg;

  // Register file
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X    = 3'd0,
    CFG_FOCAL_Y    = 3'd1,
    CFG_CENTER_X   = 3'd2,
    CFG_CENTER_Y   = 3'd3,
    CFG_INV_FX     = 3'd4,
    CFG_INV_FY     = 3'd5,
    CFG_INV_FOV    = 3'd6,
    CFG_TWICE_TAN  = 3'd7
  } cfg_idx_t;

  // Datapath widths
  localparam int FOC_W = 20;              // Q12.8 focal lengths and centres
  localparam int INV_W = 24;              // reciprocals and model terms
  localparam int MAG_W = 24;              // |xu|, |yu| in Q.20
  localparam int RU_W  = 25;              // radius
  localparam int SQ_W  = 2*MAG_W + 1;     // xu^2 + yu^2
  localparam int T_W   = 29;              // atan argument
  localparam int CX_W  = 33;              // rotator x and y
  localparam int Z_W   = 23;              // rotator angle accumulator
  localparam int ANG_W = 21;              // clamped angle
  localparam int NUM_W = ANG_W + INV_W;   // angle * inv_fov_angle
  localparam int K_W   = 24;              // scale factor
  localparam int DIV_W = RU_W + K_W;      // divider remainder
  localparam int OUT_W = 21;              // signed Q12.8 result

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Item side data handed down the chain next to the arithmetic
  typedef struct packed {
    logic [MAG_W-1:0]        xu;
    logic [MAG_W-1:0]        yu;
    logic                    nx;
    logic                    ny;
    logic [RU_W-1:0]         ru;
    logic signed [OUT_W-1:0] byp_x;
    logic signed [OUT_W-1:0] byp_y;
  } side_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic [ANG_W-1:0] atan_entry(input int idx);
    logic [ANG_W-1:0] a;
    begin
      unique case (idx)
        0:       a = 21'd823550;
        1:       a = 21'd486170;
        2:       a = 21'd256879;
        3:       a = 21'd130396;
        4:       a = 21'd65451;
        5:       a = 21'd32757;
        6:       a = 21'd16383;
        7:       a = 21'd8192;
        8:       a = 21'd4096;
        9:       a = 21'd2048;
        10:      a = 21'd1024;
        11:      a = 21'd512;
        12:      a = 21'd256;
        13:      a = 21'd128;
        14:      a = 21'd64;
        15:      a = 21'd32;
        16:      a = 21'd16;
        17:      a = 21'd8;
        18:      a = 21'd4;
        19:      a = 21'd2;
        20:      a = 21'd1;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

`default_nettype wire

// File: design/frm_sqrt_cell.sv
// One cell of the radius square-root chain: settles one root bit per cell.
// Depends on frm_pkg.
`default_nettype none

module frm_sqrt_cell
  import frm_pkg::*;
#(
  parameter int J = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [SQ_W-1:0]  rem_i,
  input  wire logic [RU_W-1:0]  root_i,
  input  wire side_t            side_i,
  output logic                  vld_o,
  output logic [SQ_W-1:0]       rem_o,
  output logic [RU_W-1:0]       root_o,
  output side_t                 side_o
);

  localparam logic [SQ_W:0]   BIT_SQ = (SQ_W+1)'(1) << (2*J);
  localparam logic [RU_W-1:0] BIT_R  = RU_W'(1) << J;

  logic [SQ_W:0]     trial;
  logic              take;
  logic [SQ_W-1:0]   rem_nxt;
  logic [RU_W-1:0]   root_nxt;

  // Try setting this root bit against the running remainder
  always_comb begin
    trial    = ({{(SQ_W+1-RU_W){1'b0}}, root_i} << (J+1)) + BIT_SQ;
    take     = ({1'b0, rem_i} >= trial);
    rem_nxt  = take ? (rem_i - trial[SQ_W-1:0]) : rem_i;
    root_nxt = take ? (root_i | BIT_R) : root_i;
  end

  // Hand on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      root_o <= root_nxt;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// File: design/frm_cordic_cell.sv
// One vectoring rotation cell of the arctangent chain.
// Depends on frm_pkg for widths, the side type and the angle table.
`default_nettype none

module frm_cordic_cell
  import frm_pkg::*;
#(
  parameter int I = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_i,
  input  wire logic signed [CX_W-1:0] x_i,
  input  wire logic signed [CX_W-1:0] y_i,
  input  wire logic signed [Z_W-1:0]  z_i,
  input  wire side_t                  side_i,
  output logic                        vld_o,
  output logic signed [CX_W-1:0]      x_o,
  output logic signed [CX_W-1:0]      y_o,
  output logic signed [Z_W-1:0]       z_o,
  output side_t                       side_o
);

  localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_entry(I));

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic                   up;

  // Rotate towards the x axis, steered by the sign of y
  always_comb begin
    xs = x_i >>> I;
    ys = y_i >>> I;
    up = !y_i[CX_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o    <= up ? (x_i + ys) : (x_i - ys);
      y_o    <= up ? (y_i - xs) : (y_i + xs);
      z_o    <= up ? (z_i + ANG) : (z_i - ANG);
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// File: design/frm_div_cell.sv
// One restoring-division cell of the scale-factor chain: one quotient bit.
// Depends on frm_pkg.
`default_nettype none

module frm_div_cell
  import frm_pkg::*;
#(
  parameter int J = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [DIV_W-1:0]  rem_i,
  input  wire logic [K_W-1:0]    q_i,
  input  wire logic              ovf_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output logic [DIV_W-1:0]       rem_o,
  output logic [K_W-1:0]         q_o,
  output logic                   ovf_o,
  output side_t                  side_o
);

  localparam logic [K_W-1:0] BIT_Q = K_W'(1) << J;

  logic [DIV_W-1:0] dsh;
  logic             take;

  // Compare against the radius shifted to this bit
  always_comb begin
    dsh  = DIV_W'(side_i.ru) << J;
    take = (rem_i >= dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= take ? (rem_i - dsh) : rem_i;
      q_o    <= take ? (q_i | BIT_Q) : q_i;
      ovf_o  <= ovf_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// File: design/fov_fisheye_rectify_map.sv
// Fisheye rectification map, top level: pipeline of arithmetic stages and cell chains.
// Depends on frm_pkg, frm_sqrt_cell, frm_cordic_cell and frm_div_cell.
//
// Usage: one item per pixel enters on in_valid/in_ready (row, column) and one
// item leaves on out_valid/out_ready (signed Q12.8 source column and row).
// Configuration is written through cfg_we/cfg_idx/cfg_data, one register per
// cycle; the user must write it only while no item is in flight, as the block itself does not enforce this.
// Throughput: one item per cycle while the skid register is empty. The path from
// the accepting edge to out_valid runs through six input and multiply stages,
// 25 square-root cells, two stages, the rotation cells, two stages, 24 divider
// cells, three output multiply stages and the output register, the first of
// which loads at the accepting edge.
// The whole chain advances together; a skid register behind the output register
// takes one more item when the receiver stalls, after which in_ready drops until
// the skid register drains.
// Reset clears all valid bits and loads the register defaults (no distortion).
`default_nettype none

module fov_fisheye_rectify_map
  import frm_pkg::*;
#(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   in_pixel_row,
  input  wire logic [COORD_BITS-1:0]   in_pixel_col,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_source_x,
  output logic signed [OUT_W-1:0]      out_source_y
);

  localparam int PQ_W   = COORD_BITS + 8;
  localparam int DW     = (PQ_W > FOC_W) ? PQ_W : FOC_W;
  localparam int PX_W   = DW + INV_W;
  localparam int SQM_W  = 2*MAG_W;
  localparam int MT_W   = RU_W + INV_W;
  localparam int PM_W   = MAG_W + K_W;
  localparam int XD_W   = 29;
  localparam int PF_W   = XD_W + FOC_W;
  localparam int OFF_W  = 30;
  localparam int FIN_W  = 32;
  localparam int OUT_HI = 1048575;
  localparam int OUT_LO = -1048576;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [FOC_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [INV_W-1:0] inv_fx_r, inv_fy_r, inv_fov_r, twice_tan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r   <= FOC_W'(65536);
      focal_y_r   <= FOC_W'(65536);
      center_x_r  <= FOC_W'(81920);
      center_y_r  <= FOC_W'(61440);
      inv_fx_r    <= INV_W'(4096);
      inv_fy_r    <= INV_W'(4096);
      inv_fov_r   <= '0;
      twice_tan_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FOCAL_X:   focal_x_r   <= cfg_data[FOC_W-1:0];
        CFG_FOCAL_Y:   focal_y_r   <= cfg_data[FOC_W-1:0];
        CFG_CENTER_X:  center_x_r  <= cfg_data[FOC_W-1:0];
        CFG_CENTER_Y:  center_y_r  <= cfg_data[FOC_W-1:0];
        CFG_INV_FX:    inv_fx_r    <= cfg_data;
        CFG_INV_FY:    inv_fy_r    <= cfg_data;
        CFG_INV_FOV:   inv_fov_r   <= cfg_data;
        CFG_TWICE_TAN: twice_tan_r <= cfg_data;
      endcase
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [FIN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    begin
      if (v > FIN_W'(OUT_HI)) begin
        r = OUT_W'(OUT_HI);
      end else if (v < FIN_W'(OUT_LO)) begin
        r = OUT_W'(OUT_LO);
      end else begin
        r = v[OUT_W-1:0];
      end
      return r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Chain advance: everything moves together unless the skid register is full
  logic adv;
  logic skid_v_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: capture the item
  logic                  v0_r;
  logic [COORD_BITS-1:0] row0_r, col0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row0_r <= in_pixel_row;
      col0_r <= in_pixel_col;
    end
  end

  // Stage 1: centre the coordinate, keep the pass-through result
  logic                    v1_r;
  logic [DW-1:0]           dx1_r, dy1_r;
  logic                    nx1_r, ny1_r;
  logic signed [OUT_W-1:0] bx1_r, by1_r;
  logic [DW-1:0]           pqx, pqy, cxe, cye;

  always_comb begin
    pqx = DW'({col0_r, 8'h00});
    pqy = DW'({row0_r, 8'h00});
    cxe = DW'(center_x_r);
    cye = DW'(center_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1_r <= (pqx < cxe);
      ny1_r <= (pqy < cye);
      dx1_r <= (pqx < cxe) ? (cxe - pqx) : (pqx - cxe);
      dy1_r <= (pqy < cye) ? (cye - pqy) : (pqy - cye);
      bx1_r <= sat_out(FIN_W'(pqx));
      by1_r <= sat_out(FIN_W'(pqy));
    end
  end

  // Stage 2: scale by the reciprocal focal lengths
  logic                    v2_r;
  logic [PX_W-1:0]         px2_r, py2_r;
  logic                    nx2_r, ny2_r;
  logic signed [OUT_W-1:0] bx2_r, by2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px2_r <= PX_W'(dx1_r) * PX_W'(inv_fx_r);
      py2_r <= PX_W'(dy1_r) * PX_W'(inv_fy_r);
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      bx2_r <= bx1_r;
      by2_r <= by1_r;
    end
  end

  // Stage 3: round to Q.20 and saturate the magnitudes
  logic                    v3_r;
  logic [MAG_W-1:0]        xu3_r, yu3_r;
  logic                    nx3_r, ny3_r;
  logic signed [OUT_W-1:0] bx3_r, by3_r;
  logic [PX_W:0]           rxs, rys;

  always_comb begin
    rxs = ((PX_W+1)'(px2_r) + (PX_W+1)'(2048)) >> 12;
    rys = ((PX_W+1)'(py2_r) + (PX_W+1)'(2048)) >> 12;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xu3_r <= (rxs > (PX_W+1)'(MAG_MAX)) ? MAG_MAX : rxs[MAG_W-1:0];
      yu3_r <= (rys > (PX_W+1)'(MAG_MAX)) ? MAG_MAX : rys[MAG_W-1:0];
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      bx3_r <= bx2_r;
      by3_r <= by2_r;
    end
  end

  // Stage 4: squares
  logic                    v4_r;
  logic [SQM_W-1:0]        sqx4_r, sqy4_r;
  logic [MAG_W-1:0]        xu4_r, yu4_r;
  logic                    nx4_r, ny4_r;
  logic signed [OUT_W-1:0] bx4_r, by4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx4_r <= SQM_W'(xu3_r) * SQM_W'(xu3_r);
      sqy4_r <= SQM_W'(yu3_r) * SQM_W'(yu3_r);
      xu4_r  <= xu3_r;
      yu4_r  <= yu3_r;
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
      bx4_r  <= bx3_r;
      by4_r  <= by3_r;
    end
  end

  // Stage 5: sum of squares, gather the side data
  logic            v5_r;
  logic [SQ_W-1:0] sum5_r;
  side_t           side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum5_r        <= SQ_W'(sqx4_r) + SQ_W'(sqy4_r);
      side5_r.xu    <= xu4_r;
      side5_r.yu    <= yu4_r;
      side5_r.nx    <= nx4_r;
      side5_r.ny    <= ny4_r;
      side5_r.ru    <= '0;
      side5_r.byp_x <= bx4_r;
      side5_r.byp_y <= by4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square-root chain, most significant root bit first
  logic            sq_v    [0:RU_W];
  logic [SQ_W-1:0] sq_rem  [0:RU_W];
  logic [RU_W-1:0] sq_root [0:RU_W];
  side_t           sq_side [0:RU_W];

  assign sq_v[0]    = v5_r;
  assign sq_rem[0]  = sum5_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_r;

  for (genvar j = 0; j < RU_W; j++) begin : g_sqrt
    frm_sqrt_cell #(.J(RU_W-1-j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_v[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .side_i (sq_side[j]),
      .vld_o  (sq_v[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .side_o (sq_side[j+1])
    );
  end

  // Stage 6: radius times 2*tan(w/2)
  logic            v6_r;
  logic [MT_W-1:0] mt6_r;
  side_t           side6_r;
  side_t           side6_nxt;

  // Fold the finished radius into the side data
  always_comb begin
    side6_nxt    = sq_side[RU_W];
    side6_nxt.ru = sq_root[RU_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= sq_v[RU_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mt6_r   <= MT_W'(sq_root[RU_W]) * MT_W'(twice_tan_r);
      side6_r <= side6_nxt;
    end
  end

  // Stage 7: round the atan argument
  logic            v7_r;
  logic [T_W-1:0]  t7_r;
  side_t           side7_r;
  logic [MT_W:0]   mts;

  assign mts = ((MT_W+1)'(mt6_r) + (MT_W+1)'(524288)) >> 20;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t7_r    <= mts[T_W-1:0];
      side7_r <= side6_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Arctangent chain
  logic                   co_v    [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] co_x    [0:CORDIC_STAGES];
  logic signed [CX_W-1:0] co_y    [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  co_z    [0:CORDIC_STAGES];
  side_t                  co_side [0:CORDIC_STAGES];

  assign co_v[0]    = v7_r;
  assign co_x[0]    = CX_W'(1048576);
  assign co_y[0]    = CX_W'(t7_r);
  assign co_z[0]    = '0;
  assign co_side[0] = side7_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    frm_cordic_cell #(.I(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (co_v[i]),
      .x_i    (co_x[i]),
      .y_i    (co_y[i]),
      .z_i    (co_z[i]),
      .side_i (co_side[i]),
      .vld_o  (co_v[i+1]),
      .x_o    (co_x[i+1]),
      .y_o    (co_y[i+1]),
      .z_o    (co_z[i+1]),
      .side_o (co_side[i+1])
    );
  end

  // Stage 8: clamp the angle at zero and scale by 1/w
  logic             v8_r;
  logic [NUM_W-1:0] num8_r;
  side_t            side8_r;
  logic [ANG_W-1:0] ang;

  assign ang = co_z[CORDIC_STAGES][Z_W-1] ? '0 : co_z[CORDIC_STAGES][ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= co_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num8_r  <= NUM_W'(ang) * NUM_W'(inv_fov_r);
      side8_r <= co_side[CORDIC_STAGES];
    end
  end

  // Stage 9: add half the radius, flag a quotient beyond the saturation limit
  logic             v9_r;
  logic [DIV_W-1:0] rem9_r;
  logic             ovf9_r;
  side_t            side9_r;
  logic [DIV_W-1:0] nn;

  assign nn = DIV_W'(num8_r) + DIV_W'(side8_r.ru >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (adv) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem9_r  <= nn;
      ovf9_r  <= ((nn >> K_W) >= DIV_W'(side8_r.ru));
      side9_r <= side8_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain, most significant quotient bit first
  logic             dv_v    [0:K_W];
  logic [DIV_W-1:0] dv_rem  [0:K_W];
  logic [K_W-1:0]   dv_q    [0:K_W];
  logic             dv_ovf  [0:K_W];
  side_t            dv_side [0:K_W];

  assign dv_v[0]    = v9_r;
  assign dv_rem[0]  = rem9_r;
  assign dv_q[0]    = '0;
  assign dv_ovf[0]  = ovf9_r;
  assign dv_side[0] = side9_r;

  for (genvar j = 0; j < K_W; j++) begin : g_div
    frm_div_cell #(.J(K_W-1-j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (dv_v[j]),
      .rem_i  (dv_rem[j]),
      .q_i    (dv_q[j]),
      .ovf_i  (dv_ovf[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_v[j+1]),
      .rem_o  (dv_rem[j+1]),
      .q_o    (dv_q[j+1]),
      .ovf_o  (dv_ovf[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // Stage 10: saturate k and scale the normalised terms
  logic            v10_r;
  logic [PM_W-1:0] pmx10_r, pmy10_r;
  side_t           side10_r;
  logic [K_W-1:0]  kf;

  assign kf = dv_ovf[K_W] ? '1 : dv_q[K_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (adv) begin
      v10_r <= dv_v[K_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pmx10_r  <= PM_W'(dv_side[K_W].xu) * PM_W'(kf);
      pmy10_r  <= PM_W'(dv_side[K_W].yu) * PM_W'(kf);
      side10_r <= dv_side[K_W];
    end
  end

  // Stage 11: round the distorted terms
  logic            v11_r;
  logic [XD_W-1:0] xd11_r, yd11_r;
  side_t           side11_r;
  logic [PM_W:0]   pxs, pys;

  always_comb begin
    pxs = ((PM_W+1)'(pmx10_r) + (PM_W+1)'(524288)) >> 20;
    pys = ((PM_W+1)'(pmy10_r) + (PM_W+1)'(524288)) >> 20;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else if (adv) begin
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xd11_r   <= pxs[XD_W-1:0];
      yd11_r   <= pys[XD_W-1:0];
      side11_r <= side10_r;
    end
  end

  // Stage 12: back to pixels
  logic            v12_r;
  logic [PF_W-1:0] pfx12_r, pfy12_r;
  side_t           side12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else if (adv) begin
      v12_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pfx12_r  <= PF_W'(xd11_r) * PF_W'(focal_x_r);
      pfy12_r  <= PF_W'(yd11_r) * PF_W'(focal_y_r);
      side12_r <= side11_r;
    end
  end

  // Offset from the principal point, saturate, pick the pass-through case
  logic [PF_W:0]           ofx, ofy;
  logic signed [FIN_W-1:0] cxs, cys, oxs, oys, sx, sy;
  logic                    byp;
  logic signed [OUT_W-1:0] fin_x, fin_y;

  always_comb begin
    ofx   = ((PF_W+1)'(pfx12_r) + (PF_W+1)'(524288)) >> 20;
    ofy   = ((PF_W+1)'(pfy12_r) + (PF_W+1)'(524288)) >> 20;
    cxs   = FIN_W'(center_x_r);
    cys   = FIN_W'(center_y_r);
    oxs   = FIN_W'(ofx[OFF_W-1:0]);
    oys   = FIN_W'(ofy[OFF_W-1:0]);
    sx    = side12_r.nx ? (cxs - oxs) : (cxs + oxs);
    sy    = side12_r.ny ? (cys - oys) : (cys + oys);
    byp   = (inv_fov_r == '0) || (side12_r.ru == '0);
    fin_x = byp ? side12_r.byp_x : sat_out(sx);
    fin_y = byp ? side12_r.byp_y : sat_out(sy);
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register
  logic                    p_fire;
  logic                    out_v_r, out_v_nxt;
  logic signed [OUT_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                    skid_v_nxt;
  logic signed [OUT_W-1:0] skid_x_r, skid_x_nxt, skid_y_r, skid_y_nxt;

  assign p_fire = v12_r && adv;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    skid_v_nxt = skid_v_r;
    skid_x_nxt = skid_x_r;
    skid_y_nxt = skid_y_r;
    priority if (out_v_r && !out_ready) begin
      // hold the output, park a newly finished item
      if (p_fire) begin
        skid_v_nxt = 1'b1;
        skid_x_nxt = fin_x;
        skid_y_nxt = fin_y;
      end
    end else if (skid_v_r) begin
      // drain the parked item
      out_v_nxt  = 1'b1;
      out_x_nxt  = skid_x_r;
      out_y_nxt  = skid_y_r;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt = p_fire;
      out_x_nxt = fin_x;
      out_y_nxt = fin_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    skid_x_r <= skid_x_nxt;
    skid_y_r <= skid_y_nxt;
  end

  assign out_valid    = out_v_r;
  assign out_source_x = out_x_r;
  assign out_source_y = out_y_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid register filled without a stalled output");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    p_fire |=> (out_v_r || skid_v_r))
    else $error("finished item lost at the output");
`endif

endmodule

`default_nettype wire
